// File: rtl/smm_pkg.sv
`default_nettype none

package smm_pkg;

    localparam longint ROM_BYTES   = 32768;
    localparam longint RAM_START   = 65536;
    localparam longint RAM_BYTES   = 32768;
    localparam longint STACK_START = 131072;
    localparam longint STACK_BYTES = 8192;

    localparam longint ROM_WORDS = (ROM_BYTES + 3) / 4;
    localparam longint RAM_WORDS = (RAM_BYTES + 3) / 4;
    localparam longint STK_WORDS = (STACK_BYTES + 3) / 4;

    localparam int ROM_AW = (ROM_WORDS > 1) ? $clog2(ROM_WORDS) : 1;
    localparam int RAM_AW = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
    localparam int STK_AW = (STK_WORDS > 1) ? $clog2(STK_WORDS) : 1;

    localparam longint MAX_WORDS_A = (ROM_WORDS > RAM_WORDS) ? ROM_WORDS : RAM_WORDS;
    localparam longint MAX_WORDS   = (MAX_WORDS_A > STK_WORDS) ? MAX_WORDS_A : STK_WORDS;
    localparam int     CLR_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    localparam logic [32:0] ROM_END   = 33'(ROM_BYTES);
    localparam logic [32:0] RAM_LO    = 33'(RAM_START);
    localparam logic [32:0] RAM_END   = 33'(RAM_START) + 33'(RAM_BYTES);
    localparam logic [32:0] STK_LO    = 33'(STACK_START);
    localparam logic [32:0] STK_END   = 33'(STACK_START) + 33'(STACK_BYTES);

    localparam logic [31:0] UART_ADDR_A     = 32'h8000_0024;
    localparam logic [31:0] UART_ADDR_B     = 32'h080A_000C;
    localparam logic [31:0] UART_READ_VALUE = 32'h0000_0100;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_WIDE = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_ROM_WRITE   = 3'd1;
    localparam logic [2:0] ST_RANGE       = 3'd2;
    localparam logic [2:0] ST_MISALIGN    = 3'd3;
    localparam logic [2:0] ST_MISALIGN_RD = 3'd4;

    typedef enum logic [2:0] {
        SRC_NONE = 3'd0,
        SRC_UART = 3'd1,
        SRC_RET  = 3'd2,
        SRC_ROM  = 3'd3,
        SRC_RAM  = 3'd4,
        SRC_STK  = 3'd5
    } src_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  status;
        logic        uart_valid;
        logic [7:0]  uart_char;
    } rsp_t;

    typedef struct packed {
        src_t              src;
        logic [1:0]        size;
        logic [1:0]        off;
        logic [2:0]        status;
        logic              uart_valid;
        logic [7:0]        uart_char;
        logic              ret_en;
        logic              rom_en;
        logic              ram_en;
        logic              stk_en;
        logic              we;
        logic [3:0]        be;
        logic [31:0]       wdata;
        logic [ROM_AW-1:0] rom_idx;
        logic [RAM_AW-1:0] ram_idx;
        logic [STK_AW-1:0] stk_idx;
    } access_t;

endpackage

`default_nettype wire

// File: rtl/stack_cpu_memory_map.sv
// Memory map of a big-endian 32-bit stack processor: a one-word return area,
// ROM, RAM and stack, plus two UART addresses. One access is accepted per
// cycle while no clear pass runs and rsp_ready does not hold back a response;
// its response appears in the cycle after, held until taken. Each store has a
// single registered read port. Byte and halfword writes go straight to the
// stores through byte enables. After reset the stores are cleared one word per
// cycle, through as many words as the largest store has (8192 at the default
// sizes); req_ready stays low during that pass.
`default_nettype none

module stack_cpu_memory_map (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire smm_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output smm_pkg::rsp_t      rsp
);

    localparam logic [smm_pkg::CLR_W-1:0] CLR_LAST =
        smm_pkg::CLR_W'(smm_pkg::MAX_WORDS - 1);

    smm_pkg::access_t acc;
    logic             take;

    logic                      clearing_reg, clearing_next;
    logic [smm_pkg::CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic                      s1_valid_reg, s1_valid_next;
    logic [31:0]               ret_reg, ret_next;
    logic [31:0]               ret_rdata_reg, ret_rdata_next;
    smm_pkg::src_t             src_reg, src_next;
    logic [1:0]                size_reg, size_next;
    logic [1:0]                off_reg, off_next;
    logic [2:0]                status_reg, status_next;
    logic                      uart_valid_reg, uart_valid_next;
    logic [7:0]                uart_char_reg, uart_char_next;

    logic                      rom_we, rom_re, ram_we, ram_re, stk_we, stk_re;
    logic [3:0]                rom_be, ram_be, stk_be;
    logic [31:0]               rom_wd, ram_wd, stk_wd;
    logic [smm_pkg::ROM_AW-1:0] rom_addr;
    logic [smm_pkg::RAM_AW-1:0] ram_addr;
    logic [smm_pkg::STK_AW-1:0] stk_addr;
    logic [31:0]               rom_rdata, ram_rdata, stk_rdata;
    logic [31:0]               word;

    smm_decode u_decode (
        .req (req),
        .acc (acc)
    );

    assign req_ready = !clearing_reg && (!s1_valid_reg || rsp_ready);
    assign take      = req_valid && req_ready;

    // stores: clear pass shares the single port
    always_comb
    begin
        if (clearing_reg)
        begin
            rom_we   = 33'(clr_cnt_reg) < 33'(smm_pkg::ROM_WORDS);
            ram_we   = 33'(clr_cnt_reg) < 33'(smm_pkg::RAM_WORDS);
            stk_we   = 33'(clr_cnt_reg) < 33'(smm_pkg::STK_WORDS);
            rom_re   = 1'b0;
            ram_re   = 1'b0;
            stk_re   = 1'b0;
            rom_be   = 4'b1111;
            ram_be   = 4'b1111;
            stk_be   = 4'b1111;
            rom_wd   = '0;
            ram_wd   = '0;
            stk_wd   = '0;
            rom_addr = clr_cnt_reg[smm_pkg::ROM_AW-1:0];
            ram_addr = clr_cnt_reg[smm_pkg::RAM_AW-1:0];
            stk_addr = clr_cnt_reg[smm_pkg::STK_AW-1:0];
        end
        else
        begin
            rom_we   = take && acc.rom_en && acc.we;
            ram_we   = take && acc.ram_en && acc.we;
            stk_we   = take && acc.stk_en && acc.we;
            rom_re   = take && acc.rom_en && !acc.we;
            ram_re   = take && acc.ram_en && !acc.we;
            stk_re   = take && acc.stk_en && !acc.we;
            rom_be   = acc.be;
            ram_be   = acc.be;
            stk_be   = acc.be;
            rom_wd   = acc.wdata;
            ram_wd   = acc.wdata;
            stk_wd   = acc.wdata;
            rom_addr = acc.rom_idx;
            ram_addr = acc.ram_idx;
            stk_addr = acc.stk_idx;
        end
    end

    smm_ram #(.DEPTH(int'(smm_pkg::ROM_WORDS)), .AW(smm_pkg::ROM_AW)) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .re    (rom_re),
        .be    (rom_be),
        .addr  (rom_addr),
        .wdata (rom_wd),
        .rdata (rom_rdata)
    );

    smm_ram #(.DEPTH(int'(smm_pkg::RAM_WORDS)), .AW(smm_pkg::RAM_AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .be    (ram_be),
        .addr  (ram_addr),
        .wdata (ram_wd),
        .rdata (ram_rdata)
    );

    smm_ram #(.DEPTH(int'(smm_pkg::STK_WORDS)), .AW(smm_pkg::STK_AW)) u_stk (
        .clk   (clk),
        .we    (stk_we),
        .re    (stk_re),
        .be    (stk_be),
        .addr  (stk_addr),
        .wdata (stk_wd),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_LAST)
            begin
                clearing_next = 1'b0;
                clr_cnt_next  = '0;
            end
        end

        s1_valid_next = take ? 1'b1 : (rsp_ready ? 1'b0 : s1_valid_reg);

        ret_next = ret_reg;
        if (take && acc.ret_en && acc.we)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (acc.be[b])
                begin
                    ret_next[8*b +: 8] = acc.wdata[8*b +: 8];
                end
            end
        end

        ret_rdata_next  = ret_rdata_reg;
        src_next        = src_reg;
        size_next       = size_reg;
        off_next        = off_reg;
        status_next     = status_reg;
        uart_valid_next = uart_valid_reg;
        uart_char_next  = uart_char_reg;
        if (take)
        begin
            ret_rdata_next  = ret_reg;
            src_next        = acc.src;
            size_next       = acc.size;
            off_next        = acc.off;
            status_next     = acc.status;
            uart_valid_next = acc.uart_valid;
            uart_char_next  = acc.uart_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            ret_reg      <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            s1_valid_reg <= s1_valid_next;
            ret_reg      <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_rdata_reg  <= ret_rdata_next;
        src_reg        <= src_next;
        size_reg       <= size_next;
        off_reg        <= off_next;
        status_reg     <= status_next;
        uart_valid_reg <= uart_valid_next;
        uart_char_reg  <= uart_char_next;
    end

    // big-endian lane select on the held word
    always_comb
    begin
        case (src_reg)
            smm_pkg::SRC_UART: word = smm_pkg::UART_READ_VALUE;
            smm_pkg::SRC_RET:  word = ret_rdata_reg;
            smm_pkg::SRC_ROM:  word = rom_rdata;
            smm_pkg::SRC_RAM:  word = ram_rdata;
            smm_pkg::SRC_STK:  word = stk_rdata;
            default:           word = '0;
        endcase

        rsp.status     = status_reg;
        rsp.uart_valid = uart_valid_reg;
        rsp.uart_char  = uart_char_reg;
        case (size_reg)
            smm_pkg::SZ_BYTE:
            begin
                case (off_reg)
                    2'd0:    rsp.read_data = {24'd0, word[31:24]};
                    2'd1:    rsp.read_data = {24'd0, word[23:16]};
                    2'd2:    rsp.read_data = {24'd0, word[15:8]};
                    default: rsp.read_data = {24'd0, word[7:0]};
                endcase
            end
            smm_pkg::SZ_HALF:
            begin
                rsp.read_data = off_reg[1] ? {16'd0, word[15:0]} : {16'd0, word[31:16]};
            end
            default:
            begin
                rsp.read_data = word;
            end
        endcase
    end

    assign rsp_valid = s1_valid_reg;

`ifndef SYNTHESIS
    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !req_ready)
        else $error("request taken during clear pass");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (!s1_valid_reg || rsp_ready))
        else $error("response overwritten before it was taken");

    a_uart_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.uart_valid) |-> (rsp.status == smm_pkg::ST_OK &&
                                           rsp.read_data == 32'd0))
        else $error("uart beat with data or error");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != smm_pkg::ST_OK &&
         rsp.status != smm_pkg::ST_MISALIGN_RD) |-> (rsp.read_data == 32'd0 &&
                                                     !rsp.uart_valid))
        else $error("error response carries data");

    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (clearing_reg && clr_cnt_reg == CLR_LAST) |=> !clearing_reg)
        else $error("clear pass did not end");
`endif

endmodule

`default_nettype wire

// File: rtl/smm_ram.sv
`default_nettype none

module smm_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [3:0]    be,
    input  wire logic [AW-1:0] addr,
    input  wire logic [31:0]   wdata,
    output logic      [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (be[b])
                begin
                    mem[addr][8*b +: 8] <= wdata[8*b +: 8];
                end
            end
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/smm_decode.sv
`default_nettype none

module smm_decode (
    input  wire smm_pkg::req_t req,
    output smm_pkg::access_t   acc
);

    logic [1:0]  size;
    logic [1:0]  off;
    logic [31:0] waddr;
    logic [32:0] wa;
    logic [31:0] ram_off;
    logic [31:0] stk_off;
    logic        is_word;
    logic        is_read;
    logic        uart_hit;
    logic        misaligned;
    logic        hit_ret;
    logic        hit_rom;
    logic        hit_ram;
    logic        hit_stk;
    logic [3:0]  be;
    logic [31:0] wdata;

    assign size     = (req.access_size == smm_pkg::SZ_WIDE) ? smm_pkg::SZ_WORD : req.access_size;
    assign off      = req.address[1:0];
    assign waddr    = {req.address[31:2], 2'b00};
    assign wa       = {1'b0, waddr};
    assign ram_off  = waddr - smm_pkg::RAM_LO[31:0];
    assign stk_off  = waddr - smm_pkg::STK_LO[31:0];
    assign is_word  = (size == smm_pkg::SZ_WORD);
    assign is_read  = (req.req_type == smm_pkg::REQ_READ);
    assign uart_hit = is_word && req.req_type != smm_pkg::REQ_LOAD &&
                      (req.address == smm_pkg::UART_ADDR_A ||
                       req.address == smm_pkg::UART_ADDR_B);
    assign misaligned = (size == smm_pkg::SZ_HALF && off[0]) ||
                        (is_word && !is_read && off != 2'b00);

    assign hit_ret = (req.address[31:2] == 30'd0);
    assign hit_rom = !hit_ret && wa < smm_pkg::ROM_END;
    assign hit_ram = !hit_ret && !hit_rom &&
                     wa >= smm_pkg::RAM_LO && wa < smm_pkg::RAM_END;
    assign hit_stk = !hit_ret && !hit_rom && !hit_ram &&
                     wa >= smm_pkg::STK_LO && wa < smm_pkg::STK_END;

    always_comb
    begin
        case (size)
            smm_pkg::SZ_BYTE:
            begin
                be    = 4'b1000 >> off;
                wdata = {4{req.write_data[7:0]}};
            end
            smm_pkg::SZ_HALF:
            begin
                be    = off[1] ? 4'b0011 : 4'b1100;
                wdata = {2{req.write_data[15:0]}};
            end
            default:
            begin
                be    = 4'b1111;
                wdata = req.write_data;
            end
        endcase
    end

    always_comb
    begin
        acc            = '0;
        acc.src        = smm_pkg::SRC_NONE;
        acc.size       = size;
        acc.off        = off;
        acc.be         = be;
        acc.wdata      = wdata;
        acc.we         = !is_read;
        acc.rom_idx    = waddr[smm_pkg::ROM_AW+1:2];
        acc.ram_idx    = ram_off[smm_pkg::RAM_AW+1:2];
        acc.stk_idx    = stk_off[smm_pkg::STK_AW+1:2];
        acc.status     = smm_pkg::ST_OK;
        if (req.req_type == smm_pkg::REQ_NONE)
        begin
            acc.we = 1'b0;
        end
        else if (uart_hit)
        begin
            if (is_read)
            begin
                acc.src = smm_pkg::SRC_UART;
            end
            else
            begin
                acc.uart_valid = 1'b1;
                acc.uart_char  = req.write_data[7:0];
            end
        end
        else if (misaligned)
        begin
            acc.status = smm_pkg::ST_MISALIGN;
        end
        else if (!(hit_ret || hit_rom || hit_ram || hit_stk))
        begin
            acc.status = smm_pkg::ST_RANGE;
        end
        else if (hit_rom && req.req_type == smm_pkg::REQ_WRITE)
        begin
            acc.status = smm_pkg::ST_ROM_WRITE;
        end
        else
        begin
            acc.ret_en = hit_ret;
            acc.rom_en = hit_rom;
            acc.ram_en = hit_ram;
            acc.stk_en = hit_stk;
            if (is_read)
            begin
                if (hit_ret)
                begin
                    acc.src = smm_pkg::SRC_RET;
                end
                else if (hit_rom)
                begin
                    acc.src = smm_pkg::SRC_ROM;
                end
                else if (hit_ram)
                begin
                    acc.src = smm_pkg::SRC_RAM;
                end
                else
                begin
                    acc.src = smm_pkg::SRC_STK;
                end
                if (is_word && off != 2'b00)
                begin
                    acc.status = smm_pkg::ST_MISALIGN_RD;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/stack_cpu_memory_map_tb.sv
`default_nettype none

module stack_cpu_memory_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 600_000;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_ready;
    smm_pkg::req_t  req;
    logic           rsp_valid;
    logic           rsp_ready;
    smm_pkg::rsp_t  rsp;

    logic [31:0] ret_word = '0;
    logic [31:0] rom_img [smm_pkg::ROM_WORDS] = '{default: '0};
    logic [31:0] ram_img [smm_pkg::RAM_WORDS] = '{default: '0};
    logic [31:0] stk_img [smm_pkg::STK_WORDS] = '{default: '0};

    smm_pkg::rsp_t rsp_expected [$];
    int            mismatches = 0;
    bit            gaps_on = 1'b1;
    int unsigned   cycle_count = 0;

    stack_cpu_memory_map i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Applies one access to the memory image and returns the response it should produce.
    function automatic smm_pkg::rsp_t mem_access(smm_pkg::req_t r);
        smm_pkg::rsp_t o;
        logic [1:0]    sz;
        logic [31:0]   wa;
        logic [31:0]   cur;
        logic [31:0]   mask;
        int            sh;
        int            idx;
        smm_pkg::src_t where;
        o = '0;
        sz = (r.access_size == smm_pkg::SZ_WIDE) ? smm_pkg::SZ_WORD : r.access_size;
        if (r.req_type == smm_pkg::REQ_NONE)
            return o;
        if (sz == smm_pkg::SZ_WORD && r.req_type != smm_pkg::REQ_LOAD &&
            (r.address == smm_pkg::UART_ADDR_A || r.address == smm_pkg::UART_ADDR_B))
        begin
            if (r.req_type == smm_pkg::REQ_READ)
                o.read_data = smm_pkg::UART_READ_VALUE;
            else
            begin
                o.uart_valid = 1'b1;
                o.uart_char  = r.write_data[7:0];
            end
            return o;
        end
        if ((sz == smm_pkg::SZ_HALF && r.address[0]) ||
            (sz == smm_pkg::SZ_WORD && r.req_type != smm_pkg::REQ_READ &&
             r.address[1:0] != 2'b00))
        begin
            o.status = smm_pkg::ST_MISALIGN;
            return o;
        end
        wa    = {r.address[31:2], 2'b00};
        where = smm_pkg::SRC_NONE;
        idx   = 0;
        cur   = '0;
        if (wa < 4)
            where = smm_pkg::SRC_RET;
        else if (wa < smm_pkg::ROM_BYTES)
        begin
            where = smm_pkg::SRC_ROM;
            idx   = int'(wa >> 2);
        end
        else if (wa >= smm_pkg::RAM_START && wa < smm_pkg::RAM_START + smm_pkg::RAM_BYTES)
        begin
            where = smm_pkg::SRC_RAM;
            idx   = int'((wa - smm_pkg::RAM_START) >> 2);
        end
        else if (wa >= smm_pkg::STACK_START &&
                 wa < smm_pkg::STACK_START + smm_pkg::STACK_BYTES)
        begin
            where = smm_pkg::SRC_STK;
            idx   = int'((wa - smm_pkg::STACK_START) >> 2);
        end
        case (where)
            smm_pkg::SRC_RET: cur = ret_word;
            smm_pkg::SRC_ROM: cur = rom_img[idx];
            smm_pkg::SRC_RAM: cur = ram_img[idx];
            smm_pkg::SRC_STK: cur = stk_img[idx];
            default:
            begin
                o.status = smm_pkg::ST_RANGE;
                return o;
            end
        endcase
        if (r.req_type == smm_pkg::REQ_WRITE && where == smm_pkg::SRC_ROM)
        begin
            o.status = smm_pkg::ST_ROM_WRITE;
            return o;
        end
        case (sz)
            smm_pkg::SZ_BYTE:
            begin
                sh   = 8 * (3 - int'(r.address[1:0]));
                mask = 32'h0000_00FF;
            end
            smm_pkg::SZ_HALF:
            begin
                sh   = r.address[1] ? 0 : 16;
                mask = 32'h0000_FFFF;
            end
            default:
            begin
                sh   = 0;
                mask = 32'hFFFF_FFFF;
            end
        endcase
        if (r.req_type == smm_pkg::REQ_READ)
        begin
            o.read_data = (cur >> sh) & mask;
            if (sz == smm_pkg::SZ_WORD && r.address[1:0] != 2'b00)
                o.status = smm_pkg::ST_MISALIGN_RD;
        end
        else
        begin
            cur = (cur & ~(mask << sh)) | ((r.write_data & mask) << sh);
            case (where)
                smm_pkg::SRC_RET: ret_word     = cur;
                smm_pkg::SRC_ROM: rom_img[idx] = cur;
                smm_pkg::SRC_RAM: ram_img[idx] = cur;
                default:          stk_img[idx] = cur;
            endcase
        end
        return o;
    endfunction

    function automatic smm_pkg::req_t mk(logic [1:0] kind, logic [1:0] sz,
                                         logic [31:0] addr, logic [31:0] data);
        smm_pkg::req_t r;
        r.req_type    = kind;
        r.access_size = sz;
        r.address     = addr;
        r.write_data  = data;
        return r;
    endfunction

    // Mostly accesses inside the regions, with small windows so reads hit earlier writes.
    function automatic smm_pkg::req_t rand_access();
        smm_pkg::req_t r;
        int            t;
        int            s;
        int            q;
        int            region;
        int            words;
        int            w;
        logic [31:0]   base;
        logic [1:0]    low;
        t = $urandom_range(0, 99);
        if (t < 40)
            r.req_type = smm_pkg::REQ_READ;
        else if (t < 70)
            r.req_type = smm_pkg::REQ_WRITE;
        else if (t < 95)
            r.req_type = smm_pkg::REQ_LOAD;
        else
            r.req_type = smm_pkg::REQ_NONE;
        s = $urandom_range(0, 99);
        if (s < 30)
            r.access_size = smm_pkg::SZ_BYTE;
        else if (s < 55)
            r.access_size = smm_pkg::SZ_HALF;
        else if (s < 95)
            r.access_size = smm_pkg::SZ_WORD;
        else
            r.access_size = smm_pkg::SZ_WIDE;
        r.write_data = $urandom();
        region = $urandom_range(0, 99);
        if (region >= 88)
        begin
            r.address = $urandom();
            return r;
        end
        if (region >= 80)
        begin
            r.address = ($urandom_range(0, 1) != 0) ? smm_pkg::UART_ADDR_A
                                                    : smm_pkg::UART_ADDR_B;
            if ($urandom_range(0, 4) != 0)
                r.access_size = smm_pkg::SZ_WORD;
            return r;
        end
        if (region < 6)
        begin
            base  = '0;
            words = 1;
        end
        else if (region < 30)
        begin
            base  = '0;
            words = int'(smm_pkg::ROM_WORDS);
        end
        else if (region < 56)
        begin
            base  = 32'(smm_pkg::RAM_START);
            words = int'(smm_pkg::RAM_WORDS);
        end
        else
        begin
            base  = 32'(smm_pkg::STACK_START);
            words = int'(smm_pkg::STK_WORDS);
        end
        q = $urandom_range(0, 19);
        if (q < 12)
            w = $urandom_range(0, (words < 16) ? words - 1 : 15);
        else if (q < 16)
            w = words - 1 - $urandom_range(0, (words < 4) ? words - 1 : 3);
        else if (q < 18)
            w = words;
        else
            w = $urandom_range(0, words - 1);
        low = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0)
        begin
            if (r.access_size == smm_pkg::SZ_HALF)
                low[0] = 1'b0;
            else if (r.access_size != smm_pkg::SZ_BYTE)
                low = 2'b00;
        end
        r.address = base + 32'(w) * 32'd4 + 32'(low);
        return r;
    endfunction

    task automatic send_beat(input smm_pkg::req_t item);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        rsp_expected.push_back(mem_access(item));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (rsp_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    task automatic test_directed_cases();
        logic [31:0] ram0;
        logic [31:0] stk_top;
        logic [31:0] ram_last;
        logic [31:0] rom_end;
        ram0     = 32'(smm_pkg::RAM_START);
        stk_top  = 32'(smm_pkg::STACK_START + smm_pkg::STACK_BYTES);
        ram_last = 32'(smm_pkg::RAM_START + smm_pkg::RAM_BYTES - 1);
        rom_end  = 32'(smm_pkg::ROM_BYTES);
        gaps_on  = 1'b1;
        send_beat(mk(smm_pkg::REQ_WRITE, smm_pkg::SZ_WORD, 32'h0, 32'hDEAD_BEEF));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_BYTE, 32'h3, 32'h0));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_HALF, 32'h0, 32'h0));
        send_beat(mk(smm_pkg::REQ_LOAD,  smm_pkg::SZ_WORD, 32'h4, 32'h0123_4567));
        send_beat(mk(smm_pkg::REQ_LOAD,  smm_pkg::SZ_BYTE, rom_end - 32'd1, 32'hFFFF_FFA5));
        send_beat(mk(smm_pkg::REQ_WRITE, smm_pkg::SZ_WORD, 32'h4, 32'hFFFF_FFFF));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_WORD, 32'h4, 32'h0));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_WORD, rom_end - 32'd4, 32'h0));
        send_beat(mk(smm_pkg::REQ_WRITE, smm_pkg::SZ_HALF, ram0 + 32'd2, 32'h1234_BEEF));
        send_beat(mk(smm_pkg::REQ_WRITE, smm_pkg::SZ_BYTE, ram0, 32'h0000_0012));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_WORD, ram0, 32'h0));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_WORD, ram0 + 32'd1, 32'h0));
        send_beat(mk(smm_pkg::REQ_WRITE, smm_pkg::SZ_BYTE, ram_last, 32'hFFFF_FFFF));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_BYTE, ram_last, 32'h0));
        send_beat(mk(smm_pkg::REQ_WRITE, smm_pkg::SZ_HALF, ram0 + 32'd1, 32'hFFFF_FFFF));
        send_beat(mk(smm_pkg::REQ_WRITE, smm_pkg::SZ_WORD, ram0 + 32'd2, 32'hFFFF_FFFF));
        send_beat(mk(smm_pkg::REQ_LOAD,  smm_pkg::SZ_WORD, 32'h6, 32'hFFFF_FFFF));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_HALF, 32'h3, 32'h0));
        send_beat(mk(smm_pkg::REQ_LOAD,  smm_pkg::SZ_HALF, stk_top - 32'd2, 32'hFFFF_FFFF));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_WORD, stk_top - 32'd4, 32'h0));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_BYTE, 32'hFFFF_FFFF, 32'h0));
        send_beat(mk(smm_pkg::REQ_WRITE, smm_pkg::SZ_WORD, rom_end, 32'h0));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_WORD, stk_top, 32'h0));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_WORD, smm_pkg::UART_ADDR_A, 32'h0));
        send_beat(mk(smm_pkg::REQ_WRITE, smm_pkg::SZ_WORD, smm_pkg::UART_ADDR_B,
                     32'hFFFF_FF41));
        send_beat(mk(smm_pkg::REQ_WRITE, smm_pkg::SZ_WIDE, smm_pkg::UART_ADDR_A,
                     32'h0000_007E));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_BYTE, smm_pkg::UART_ADDR_A, 32'h0));
        send_beat(mk(smm_pkg::REQ_LOAD,  smm_pkg::SZ_WORD, smm_pkg::UART_ADDR_B,
                     32'h0000_0055));
        send_beat(mk(smm_pkg::REQ_NONE,  smm_pkg::SZ_WORD, 32'h0, 32'hFFFF_FFFF));
        send_beat(mk(smm_pkg::REQ_READ,  smm_pkg::SZ_WIDE, 32'h0, 32'h0));
    endtask

    task automatic test_random_with_stalls();
        gaps_on = 1'b1;
        repeat (400)
            send_beat(rand_access());
    endtask

    task automatic test_random_streaming();
        gaps_on = 1'b0;
        repeat (250)
            send_beat(rand_access());
    endtask

    task automatic test_drain_midway();
        gaps_on = 1'b1;
        repeat (125)
            send_beat(rand_access());
        wait_drained();
        repeat (125)
            send_beat(rand_access());
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!gaps_on)
                rsp_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        smm_pkg::rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid === 1'b1 && rsp_ready)
            begin
                if (rsp_expected.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected response beat: expected none, actual %h",
                             $time, rsp);
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    check_field("read_data",  want.read_data,         rsp.read_data);
                    check_field("status",     32'(want.status),       32'(rsp.status));
                    check_field("uart_valid", 32'(want.uart_valid),   32'(rsp.uart_valid));
                    check_field("uart_char",  32'(want.uart_char),    32'(rsp.uart_char));
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d responses outstanding", $time, rsp_expected.size());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_with_stalls();
        test_random_streaming();
        test_drain_midway();
        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
